>>> sv/esp3_frame_sync_hex_stream_assert.svh
// Assertion macros used by the checker file.
`ifndef ESP3_FRAME_SYNC_HEX_STREAM_ASSERT_SVH
`define ESP3_FRAME_SYNC_HEX_STREAM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is also checked during reset.
`define EFS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/efs_pkg.sv
// Shared constants, command type and CRC/hex helpers for the frame sync block.
`timescale 1ns / 1ps

package efs_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_LF   = 8'd10;

    // Parser phases
    localparam logic [2:0] PH_SYNC = 3'd0;
    localparam logic [2:0] PH_LENH = 3'd1;
    localparam logic [2:0] PH_LENL = 3'd2;
    localparam logic [2:0] PH_OPT  = 3'd3;
    localparam logic [2:0] PH_TYPE = 3'd4;
    localparam logic [2:0] PH_CRC  = 3'd5;
    localparam logic [2:0] PH_BODY = 3'd6;

    // Command kinds passed from front to back
    localparam logic [1:0] KIND_CHAR = 2'd0;  // raw character
    localparam logic [1:0] KIND_END  = 2'd1;  // bare end mark
    localparam logic [1:0] KIND_HEX  = 2'd2;  // one byte as two hex chars
    localparam logic [1:0] KIND_HDR  = 2'd3;  // sync + five header bytes as hex

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [3:0] HDR_LAST_IDX = 4'd11;

    typedef struct packed {
        logic [1:0]      kind;
        logic [4:0][7:0] bytes;
        logic            last;
    } efs_cmd_t;

    // Bitwise CRC-8 of a 32-bit message, MSB first. Elaboration use only.
    function automatic logic [7:0] crc8_msg(input logic [31:0] msg);
        logic [7:0] c;
        logic       fb;
        int         k;
        c = '0;
        for (k = 31; k >= 0; k--) begin
            fb = c[7] ^ msg[k];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    // CRC contribution of each bit of the header byte at position pos (0 first).
    function automatic logic [63:0] crc_cols(input int pos);
        logic [63:0] cols;
        logic [31:0] msg;
        int          i;
        cols = '0;
        for (i = 0; i < 8; i++) begin
            msg = 32'(32'd1 << i) << (8 * (3 - pos));
            cols[8*i +: 8] = crc8_msg(msg);
        end
        return cols;
    endfunction

    localparam logic [63:0] CRC_COLS0 = crc_cols(0);
    localparam logic [63:0] CRC_COLS1 = crc_cols(1);
    localparam logic [63:0] CRC_COLS2 = crc_cols(2);
    localparam logic [63:0] CRC_COLS3 = crc_cols(3);

    // GF(2) matrix times byte: XOR of the columns of the set bits.
    function automatic logic [7:0] crc_apply(input logic [63:0] cols, input logic [7:0] x);
        logic [7:0] r;
        int         i;
        r = '0;
        for (i = 0; i < 8; i++) begin
            if (x[i])
                r = r ^ cols[8*i +: 8];
        end
        return r;
    endfunction

    // CRC-8 over the four header bytes, init 0, CRC is linear so terms add.
    function automatic logic [7:0] crc8_hdr(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
        return crc_apply(CRC_COLS0, b0) ^ crc_apply(CRC_COLS1, b1)
             ^ crc_apply(CRC_COLS2, b2) ^ crc_apply(CRC_COLS3, b3);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
    endfunction

endpackage

>>> sv/esp3_frame_sync_hex_stream.sv
// Top level of the serial frame sync and hex character streamer.
`timescale 1ns / 1ps

// Usage notes
// - Input channel (in_valid/in_stall, rx_byte, rx_error): one received serial
//   byte per transfer. Bytes flagged with rx_error are consumed and dropped.
// - Output channel (out_valid/out_stall, out_char, char_valid, msg_last): one
//   character per transfer. char_valid low marks a bare end of message.
// - Config channel (cfg_valid/cfg_ready, cfg_data): frame_mode, 0 line mode,
//   1 sync frame mode. cfg_ready is always high; write only while idle.
// - Path: a byte's first character is registered in the command queue, the
//   command register and the output register. The back end emits one character
//   per cycle while out_stall is low. An input byte yields one character (line
//   mode), two (frame body), twelve (header on a good CRC) or none. A 4-entry
//   command queue lets the parser keep taking bytes while characters drain.
// - in_stall rises only when the queue is full; out_stall holds the output
//   register, and back pressure reaches the input once the queue fills.
// - Reset (rst_n low, async): line mode, parser hunting for sync, queue and
//   output empty.

module esp3_frame_sync_hex_stream
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       rx_error,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       msg_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    efs_pkg::efs_cmd_t push_cmd;
    efs_pkg::efs_cmd_t fifo_cmd;
    logic              push;
    logic              pop;
    logic              fifo_full;
    logic              fifo_empty;

    assign cfg_ready = 1'b1;
    assign in_stall  = fifo_full;  // parser never pushes into a full queue

    efs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .rx_error (rx_error),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .push     (push),
        .push_cmd (push_cmd)
    );

    efs_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (fifo_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    efs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_cmd   (fifo_cmd),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .char_valid (char_valid),
        .msg_last   (msg_last)
    );

endmodule

>>> sv/efs_front.sv
// Front end: takes received bytes, runs the line/frame parser, queues commands.
`timescale 1ns / 1ps

module efs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             rx_error,
    input  logic             cfg_we,
    input  logic             cfg_data,
    output logic             push,
    output efs_pkg::efs_cmd_t push_cmd
);

    logic        frame_mode_reg, frame_mode_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  lh_reg, lh_next;
    logic [7:0]  ll_reg, ll_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  ty_reg, ty_next;
    logic [16:0] cnt_reg, cnt_next;
    logic [16:0] tot_reg, tot_next;

    logic        accept;
    logic [7:0]  crc_calc;
    logic [16:0] cnt_inc;

    assign accept   = in_valid && !in_stall && !rx_error;
    assign crc_calc = efs_pkg::crc8_hdr(lh_reg, ll_reg, op_reg, ty_reg);
    assign cnt_inc  = cnt_reg + 17'd1;

    always_comb
    begin
        frame_mode_next = cfg_we ? cfg_data : frame_mode_reg;
        phase_next      = phase_reg;
        lh_next         = lh_reg;
        ll_next         = ll_reg;
        op_next         = op_reg;
        ty_next         = ty_reg;
        cnt_next        = cnt_reg;
        tot_next        = tot_reg;
        push            = 1'b0;
        push_cmd        = '0;

        if (accept)
        begin
            if (!frame_mode_reg)
            begin
                if (rx_byte == efs_pkg::CHAR_LF)
                begin
                    push          = 1'b1;
                    push_cmd.kind = efs_pkg::KIND_END;
                    push_cmd.last = 1'b1;
                end
                else if (rx_byte != efs_pkg::CHAR_CR)
                begin
                    push              = 1'b1;
                    push_cmd.kind     = efs_pkg::KIND_CHAR;
                    push_cmd.bytes[0] = rx_byte;
                end
            end
            else
            begin
                unique case (phase_reg)
                    efs_pkg::PH_LENH:
                    begin
                        lh_next    = rx_byte;
                        phase_next = efs_pkg::PH_LENL;
                    end
                    efs_pkg::PH_LENL:
                    begin
                        ll_next    = rx_byte;
                        phase_next = efs_pkg::PH_OPT;
                    end
                    efs_pkg::PH_OPT:
                    begin
                        op_next    = rx_byte;
                        phase_next = efs_pkg::PH_TYPE;
                    end
                    efs_pkg::PH_TYPE:
                    begin
                        ty_next    = rx_byte;
                        phase_next = efs_pkg::PH_CRC;
                    end
                    efs_pkg::PH_CRC:
                    begin
                        // realign on the first sync byte inside the header on failure
                        priority if (crc_calc == rx_byte)
                        begin
                            push              = 1'b1;
                            push_cmd.kind     = efs_pkg::KIND_HDR;
                            push_cmd.bytes[0] = lh_reg;
                            push_cmd.bytes[1] = ll_reg;
                            push_cmd.bytes[2] = op_reg;
                            push_cmd.bytes[3] = ty_reg;
                            push_cmd.bytes[4] = rx_byte;
                            cnt_next          = '0;
                            tot_next          = {1'b0, lh_reg, ll_reg} + {9'd0, op_reg}
                                              + 17'd1;
                            phase_next        = efs_pkg::PH_BODY;
                        end
                        else if (lh_reg == efs_pkg::SYNC_BYTE)
                        begin
                            lh_next    = ll_reg;
                            ll_next    = op_reg;
                            op_next    = ty_reg;
                            ty_next    = rx_byte;
                            phase_next = efs_pkg::PH_CRC;
                        end
                        else if (ll_reg == efs_pkg::SYNC_BYTE)
                        begin
                            lh_next    = op_reg;
                            ll_next    = ty_reg;
                            op_next    = rx_byte;
                            phase_next = efs_pkg::PH_TYPE;
                        end
                        else if (op_reg == efs_pkg::SYNC_BYTE)
                        begin
                            lh_next    = ty_reg;
                            ll_next    = rx_byte;
                            phase_next = efs_pkg::PH_OPT;
                        end
                        else if (ty_reg == efs_pkg::SYNC_BYTE)
                        begin
                            lh_next    = rx_byte;
                            phase_next = efs_pkg::PH_LENL;
                        end
                        else if (rx_byte == efs_pkg::SYNC_BYTE)
                            phase_next = efs_pkg::PH_LENH;
                        else
                            phase_next = efs_pkg::PH_SYNC;
                    end
                    efs_pkg::PH_BODY:
                    begin
                        cnt_next          = cnt_inc;
                        push              = 1'b1;
                        push_cmd.kind     = efs_pkg::KIND_HEX;
                        push_cmd.bytes[0] = rx_byte;
                        push_cmd.last     = (cnt_inc >= tot_reg);
                        if (cnt_inc >= tot_reg)
                            phase_next = efs_pkg::PH_SYNC;
                    end
                    default:
                    begin
                        // hunting for sync; unused code 7 lands here too
                        phase_next = (rx_byte == efs_pkg::SYNC_BYTE) ? efs_pkg::PH_LENH
                                                                     : efs_pkg::PH_SYNC;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= 1'b0;
            phase_reg      <= efs_pkg::PH_SYNC;
            lh_reg         <= '0;
            ll_reg         <= '0;
            op_reg         <= '0;
            ty_reg         <= '0;
            cnt_reg        <= '0;
            tot_reg        <= '0;
        end
        else
        begin
            frame_mode_reg <= frame_mode_next;
            phase_reg      <= phase_next;
            lh_reg         <= lh_next;
            ll_reg         <= ll_next;
            op_reg         <= op_next;
            ty_reg         <= ty_next;
            cnt_reg        <= cnt_next;
            tot_reg        <= tot_next;
        end
    end

endmodule

>>> sv/efs_fifo.sv
// Small command queue between the parser front end and the character back end.
`timescale 1ns / 1ps

module efs_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  efs_pkg::efs_cmd_t push_cmd,
    input  logic              pop,
    output efs_pkg::efs_cmd_t pop_cmd,
    output logic              full,
    output logic              empty
);

    efs_pkg::efs_cmd_t               mem_reg [efs_pkg::FIFO_DEPTH];
    logic [efs_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [efs_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [efs_pkg::FIFO_AW:0]       count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == (efs_pkg::FIFO_AW+1)'(efs_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/efs_back.sv
// Back end: commands become registered characters, one per cycle unless stalled.
`timescale 1ns / 1ps

module efs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  efs_pkg::efs_cmd_t fifo_cmd,
    input  logic              fifo_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_char,
    output logic              char_valid,
    output logic              msg_last
);

    efs_pkg::efs_cmd_t cmd_reg, cmd_next;
    logic              cmd_valid_reg, cmd_valid_next;
    logic [3:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic              char_valid_reg, char_valid_next;
    logic              msg_last_reg, msg_last_next;

    logic              advance;
    logic              cmd_done;
    logic [3:0]        last_idx;
    logic [7:0]        sel_byte;
    logic [7:0]        hex_out;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        unique case (cmd_reg.kind)
            efs_pkg::KIND_HEX: last_idx = 4'd1;
            efs_pkg::KIND_HDR: last_idx = efs_pkg::HDR_LAST_IDX;
            default:           last_idx = 4'd0;
        endcase
    end

    // header byte order: sync, len high, len low, opt len, type, crc
    always_comb
    begin
        if (cmd_reg.kind == efs_pkg::KIND_HDR)
        begin
            unique case (idx_reg[3:1])
                3'd1:    sel_byte = cmd_reg.bytes[0];
                3'd2:    sel_byte = cmd_reg.bytes[1];
                3'd3:    sel_byte = cmd_reg.bytes[2];
                3'd4:    sel_byte = cmd_reg.bytes[3];
                3'd5:    sel_byte = cmd_reg.bytes[4];
                default: sel_byte = efs_pkg::SYNC_BYTE;
            endcase
        end
        else
            sel_byte = cmd_reg.bytes[0];
    end

    assign hex_out  = efs_pkg::hex_char(idx_reg[0] ? sel_byte[3:0] : sel_byte[7:4]);
    assign cmd_done = cmd_valid_reg && advance && (idx_reg == last_idx);
    assign pop      = !fifo_empty && (!cmd_valid_reg || cmd_done);

    always_comb
    begin
        cmd_next        = cmd_reg;
        cmd_valid_next  = cmd_valid_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        char_valid_next = char_valid_reg;
        msg_last_next   = msg_last_reg;

        if (advance)
        begin
            out_valid_next = cmd_valid_reg;
            if (cmd_valid_reg)
            begin
                idx_next = idx_reg + 4'd1;
                unique case (cmd_reg.kind)
                    efs_pkg::KIND_CHAR:
                    begin
                        out_char_next   = cmd_reg.bytes[0];
                        char_valid_next = 1'b1;
                        msg_last_next   = cmd_reg.last;
                    end
                    efs_pkg::KIND_END:
                    begin
                        out_char_next   = 8'h00;
                        char_valid_next = 1'b0;
                        msg_last_next   = 1'b1;
                    end
                    efs_pkg::KIND_HEX:
                    begin
                        out_char_next   = hex_out;
                        char_valid_next = 1'b1;
                        msg_last_next   = cmd_reg.last && idx_reg[0];
                    end
                    default:
                    begin
                        out_char_next   = hex_out;
                        char_valid_next = 1'b1;
                        msg_last_next   = 1'b0;
                    end
                endcase
            end
        end

        if (pop)
        begin
            cmd_next       = fifo_cmd;
            cmd_valid_next = 1'b1;
            idx_next       = 4'd0;
        end
        else if (cmd_done)
            cmd_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        out_char_reg   <= out_char_next;
        char_valid_reg <= char_valid_next;
        msg_last_reg   <= msg_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign msg_last   = msg_last_reg;

endmodule

>>> sv/efs_checker.sv
// Port-level assertion checker for the frame sync streamer, with its bind.
`timescale 1ns / 1ps

`include "esp3_frame_sync_hex_stream_assert.svh"

module efs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       rx_error,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       char_valid,
    input logic       msg_last
);

    logic       in_hold;
    logic [8:0] in_data;
    logic       out_hold;
    logic [9:0] out_data;
    logic       end_mark;

    assign in_hold  = in_valid && in_stall;
    assign in_data  = {rx_byte, rx_error};
    assign out_hold = out_valid && out_stall;
    assign out_data = {out_char, char_valid, msg_last};
    assign end_mark = out_valid && !char_valid;

    // stalled input transfer keeps its payload
    `EFS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_hold, in_valid && $stable(in_data), "input moved")

    // stalled output transfer keeps its payload
    `EFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_data), "output moved")

    // a bare end mark always closes the message and carries a zero char
    `EFS_ASSERT_IMP(a_end_mark, clk, rst_n, end_mark, msg_last && out_char == 8'h00, "bad end mark")

    // output is empty during reset
    `EFS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid, "valid in reset")

endmodule

bind esp3_frame_sync_hex_stream efs_checker u_efs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .rx_error   (rx_error),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .char_valid (char_valid),
    .msg_last   (msg_last)
);
